>>> rtl/lbp_3x3_image_filter_macros.svh
// assertion macros of the lbp filter checker
`ifndef LBP_3X3_IMAGE_FILTER_MACROS_SVH
`define LBP_3X3_IMAGE_FILTER_MACROS_SVH

// same-cycle implication, sampled on clk, off while in reset
`define LBP_ASSERT_SAME(label, ante, cons, msg) \
label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);

// next-cycle implication, sampled on clk, off while in reset
`define LBP_ASSERT_NEXT(label, ante, cons, msg) \
label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

>>> rtl/lbp_pkg.sv
// types, constants and functions of the lbp 3x3 image filter
package lbp_pkg;

	localparam int unsigned CFG_W     = 11;
	localparam int unsigned CFG_IDX_W = 1;
	localparam int unsigned PIX_W     = 8;
	localparam int unsigned POS_W     = 10;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'd1;

	localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 11'd640;
	localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 11'd480;

	// item kinds
	localparam logic FUNC_PIXEL = 1'b0;
	localparam logic FUNC_DRAIN = 1'b1;

	// neighbor weights in raster order, center weight zero
	localparam logic [8:0][PIX_W-1:0] LBP_WEIGHT = {
		8'd128, 8'd64, 8'd32, 8'd16, 8'd0, 8'd8, 8'd4, 8'd2, 8'd1
	};

	typedef logic [8:0][PIX_W-1:0] lbp_win_t;

	typedef struct packed {
		logic             func;
		logic [PIX_W-1:0] pixel;
	} lbp_in_t;

	typedef struct packed {
		logic [PIX_W-1:0] value;
		logic [POS_W-1:0] row;
		logic [POS_W-1:0] col;
		logic             last;
	} lbp_out_t;

	// per-item control handed from the position tracker to the datapath
	typedef struct packed {
		logic             has_res;
		logic             border;
		logic             last;
		logic [POS_W-1:0] row;
		logic [POS_W-1:0] col;
	} lbp_item_t;

	// saturate a frame size to 3..maxv and return size minus one
	function automatic int unsigned clamp_last(logic [CFG_W-1:0] v, int unsigned maxv);
		int unsigned s;
		s = int'(v);
		if (s < 3)
			s = 3;
		else if (s > maxv)
			s = maxv;
		return s - 1;
	endfunction

	// local binary pattern of a 3x3 window
	function automatic logic [PIX_W-1:0] lbp_code(lbp_win_t w);
		logic [PIX_W-1:0] code;
		code = '0;
		for (int k = 0; k < 9; k++) begin
			if (k != 4 && w[k] >= w[4])
				code = code | LBP_WEIGHT[k];
		end
		return code;
	endfunction

endpackage

>>> rtl/lbp_stream_if.sv
// valid/ready stream channel with a typed payload
interface lbp_stream_if #(
	parameter type T = logic
) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/lbp_ram.sv
// generic simple dual-port ram with registered read
module lbp_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
	end

	// registered read port, holds when not enabled
	always_ff @(posedge clk) begin
		if (re)
			rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;
endmodule

>>> rtl/lbp_pos.sv
// frame size registers and input/output position tracking
module lbp_pos import lbp_pkg::*; #(
	parameter int unsigned MAX_WIDTH  = 1024,
	parameter int unsigned MAX_HEIGHT = 1024
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [CFG_IDX_W-1:0]         cfg_index,
	input  logic [CFG_W-1:0]             cfg_data,
	input  logic                         beat,
	input  logic                         func,
	output logic                         take,
	output logic                         tail,
	output logic [$clog2(MAX_WIDTH)-1:0] ci,
	output lbp_item_t                    item
);
	localparam int unsigned COL_W = $clog2(MAX_WIDTH);
	localparam int unsigned ROW_W = $clog2(MAX_HEIGHT);
	localparam logic [COL_W-1:0] W_LAST_RST = COL_W'(clamp_last(FRAME_WIDTH_RST, MAX_WIDTH));
	localparam logic [ROW_W-1:0] H_LAST_RST = ROW_W'(clamp_last(FRAME_HEIGHT_RST, MAX_HEIGHT));

	logic [COL_W-1:0] w_last_q;
	logic [ROW_W-1:0] h_last_q;
	logic [COL_W-1:0] in_col_q;
	logic [ROW_W-1:0] in_row_q;
	logic             tail_q;
	logic [COL_W-1:0] out_col_q;
	logic [ROW_W-1:0] out_row_q;

	logic has_res;
	logic out_last;

	// drains are dropped until the whole frame is in
	assign take = beat && (tail_q || func != FUNC_DRAIN);
	assign tail = tail_q;
	assign ci   = in_col_q;

	// a result is due once one row plus one pixel has gone in
	assign has_res  = (in_row_q > ROW_W'(1)) || (in_row_q == ROW_W'(1) && in_col_q != '0);
	assign out_last = (out_row_q == h_last_q) && (out_col_q == w_last_q);

	assign item.has_res = has_res;
	assign item.last    = out_last;
	assign item.border  = (out_row_q == '0) || (out_row_q == h_last_q) ||
	                      (out_col_q == '0) || (out_col_q == w_last_q);
	assign item.row     = POS_W'(out_row_q);
	assign item.col     = POS_W'(out_col_q);

	// size registers, any write restarts the frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_last_q  <= W_LAST_RST;
			h_last_q  <= H_LAST_RST;
			in_col_q  <= '0;
			in_row_q  <= '0;
			tail_q    <= 1'b0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_FRAME_WIDTH:  w_last_q <= COL_W'(clamp_last(cfg_data, MAX_WIDTH));
				REG_FRAME_HEIGHT: h_last_q <= ROW_W'(clamp_last(cfg_data, MAX_HEIGHT));
				default: ;
			endcase
			in_col_q  <= '0;
			in_row_q  <= '0;
			tail_q    <= 1'b0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else if (take) begin
			if (has_res && out_last) begin
				// frame done
				in_col_q  <= '0;
				in_row_q  <= '0;
				tail_q    <= 1'b0;
				out_col_q <= '0;
				out_row_q <= '0;
			end else begin
				// input raster position, row holds once the tail starts
				if (in_col_q == w_last_q) begin
					in_col_q <= '0;
					if (!tail_q) begin
						if (in_row_q == h_last_q)
							tail_q <= 1'b1;
						else
							in_row_q <= in_row_q + ROW_W'(1);
					end
				end else begin
					in_col_q <= in_col_q + COL_W'(1);
				end
				// output raster position
				if (has_res) begin
					if (out_col_q == w_last_q) begin
						out_col_q <= '0;
						out_row_q <= out_row_q + ROW_W'(1);
					end else begin
						out_col_q <= out_col_q + COL_W'(1);
					end
				end
			end
		end
	end
endmodule

>>> rtl/lbp_win.sv
// item stage, 3x3 window, lbp code and output register
module lbp_win import lbp_pkg::*; #(
	parameter int unsigned MAX_WIDTH = 1024
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         load,
	input  lbp_item_t                    item,
	input  logic [$clog2(MAX_WIDTH)-1:0] ci,
	input  logic [PIX_W-1:0]             px,
	input  logic [PIX_W-1:0]             upper_rd,
	input  logic [PIX_W-1:0]             middle_rd,
	output logic                         in_ready,
	output logic                         wr_en,
	output logic [$clog2(MAX_WIDTH)-1:0] wr_addr,
	output logic [PIX_W-1:0]             upper_wd,
	output logic [PIX_W-1:0]             middle_wd,
	output logic                         out_valid,
	input  logic                         out_ready,
	output lbp_out_t                     out_data
);
	localparam int unsigned COL_W = $clog2(MAX_WIDTH);

	logic             valid_s1;
	lbp_item_t        item_s1;
	logic [COL_W-1:0] ci_s1;
	logic [PIX_W-1:0] px_s1;

	lbp_win_t win_q;
	lbp_win_t win_nxt;
	logic     out_valid_q;
	lbp_out_t out_data_q;
	logic     go;

	// the stage moves on unless its result finds the output register full
	assign go       = valid_s1 && (!item_s1.has_res || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || go;

	// line store update: middle row moves up, new pixel goes in the middle
	assign wr_en     = go;
	assign wr_addr   = ci_s1;
	assign upper_wd  = middle_rd;
	assign middle_wd = px_s1;

	// window shifted left by one column
	always_comb begin
		win_nxt = win_q;
		for (int r = 0; r < 3; r++) begin
			win_nxt[r*3+0] = win_q[r*3+1];
			win_nxt[r*3+1] = win_q[r*3+2];
		end
		win_nxt[2] = upper_rd;
		win_nxt[5] = middle_rd;
		win_nxt[8] = px_s1;
	end

	// item stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (in_ready)
			valid_s1 <= load;
	end

	// item stage payload
	always_ff @(posedge clk) begin
		if (load) begin
			item_s1 <= item;
			ci_s1   <= ci;
			px_s1   <= px;
		end
	end

	// window registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			win_q <= '0;
		else if (go)
			win_q <= win_nxt;
	end

	// output register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (go && item_s1.has_res)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (go && item_s1.has_res) begin
			out_data_q.value <= item_s1.border ? win_nxt[4] : lbp_code(win_nxt);
			out_data_q.row   <= item_s1.row;
			out_data_q.col   <= item_s1.col;
			out_data_q.last  <= item_s1.last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;
endmodule

>>> rtl/lbp_3x3_image_filter.sv
// a raster position's result is registered in the item stage and output register after the
// beat completing its window (one row and one pixel later); drain beats flush the frame tail
// throughput: one beat per cycle, the item stage and output register stall only on res.ready
// line stores are two single-port-write rams read at the column of each accepted beat
// reset clears positions and window and loads 640x480; line stores are not cleared
// the first two rows of a frame fill them, so no clearing pass is needed
module lbp_3x3_image_filter import lbp_pkg::*; #(
	parameter int unsigned MAX_WIDTH  = 1024,
	parameter int unsigned MAX_HEIGHT = 1024
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_W-1:0]       cfg_data,
	lbp_stream_if.sink             pix,
	lbp_stream_if.source           res
);
	localparam int unsigned COL_W = $clog2(MAX_WIDTH);

	lbp_in_t          in_data;
	lbp_out_t         out_data;
	lbp_item_t        item;
	logic             in_ready;
	logic             beat;
	logic             take;
	logic             tail;
	logic [COL_W-1:0] ci;
	logic [PIX_W-1:0] px;
	logic [PIX_W-1:0] upper_rd;
	logic [PIX_W-1:0] middle_rd;
	logic             wr_en;
	logic [COL_W-1:0] wr_addr;
	logic [PIX_W-1:0] upper_wd;
	logic [PIX_W-1:0] middle_wd;

	assign in_data   = pix.data;
	assign pix.ready = in_ready;
	assign beat      = pix.valid && in_ready;
	assign res.data  = out_data;

	// tail beats carry a zero pixel
	assign px = tail ? '0 : in_data.pixel;

	lbp_pos #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_pos (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.beat      (beat),
		.func      (in_data.func),
		.take      (take),
		.tail      (tail),
		.ci        (ci),
		.item      (item)
	);

	// row two above the incoming pixel
	lbp_ram #(
		.WIDTH (PIX_W),
		.DEPTH (MAX_WIDTH)
	) u_upper (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (upper_wd),
		.re    (take),
		.raddr (ci),
		.rdata (upper_rd)
	);

	// row directly above the incoming pixel
	lbp_ram #(
		.WIDTH (PIX_W),
		.DEPTH (MAX_WIDTH)
	) u_middle (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (middle_wd),
		.re    (take),
		.raddr (ci),
		.rdata (middle_rd)
	);

	lbp_win #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_win (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (take),
		.item      (item),
		.ci        (ci),
		.px        (px),
		.upper_rd  (upper_rd),
		.middle_rd (middle_rd),
		.in_ready  (in_ready),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.upper_wd  (upper_wd),
		.middle_wd (middle_wd),
		.out_valid (res.valid),
		.out_ready (res.ready),
		.out_data  (out_data)
	);
endmodule

>>> rtl/lbp_checker.sv
// port-level checker for the lbp filter and its bind
`include "lbp_3x3_image_filter_macros.svh"

module lbp_checker import lbp_pkg::*; (
	input logic     clk,
	input logic     arst_n,
	input logic     in_valid,
	input logic     in_ready,
	input logic     out_valid,
	input logic     out_ready,
	input lbp_out_t out_data
);
	// a stalled result beat stays put
	`LBP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "result beat changed while stalled")

	// with the output register empty the input side is never blocked
	`LBP_ASSERT_SAME(a_ready_when_empty, !out_valid, in_ready, "input blocked with empty output")

	// a new result follows an input beat through the item stage and the output register
	`LBP_ASSERT_SAME(a_out_latency, $rose(out_valid), $past(in_valid && in_ready, 2), "result without input beat two cycles before")

	// the next frame needs a row plus a pixel before its first result
	`LBP_ASSERT_NEXT(a_gap_after_last, out_valid && out_ready && out_data.last, !out_valid, "result right after end of frame")
endmodule

bind lbp_3x3_image_filter lbp_checker u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (pix.valid),
	.in_ready  (pix.ready),
	.out_valid (res.valid),
	.out_ready (res.ready),
	.out_data  (res.data)
);

>>> tb/lbp_3x3_image_filter_tb.sv
// self-checking testbench of the lbp 3x3 image filter against a line-buffer predictor
module lbp_3x3_image_filter_tb;
	import lbp_pkg::*;

	localparam int unsigned MAX_W       = 1024;
	localparam int unsigned MAX_H       = 1024;
	localparam int unsigned IDLE_PCT    = 32;
	localparam int unsigned SETTLE      = 6;
	localparam int unsigned HOLD_CYCLES = 400;
	localparam int unsigned STALL_LIMIT = 4000;
	localparam int unsigned RAND_ITEMS  = 200;

	// raster order, first pixel in the low byte: center 128 against both extremes and ties
	localparam logic [8:0][PIX_W-1:0] PATCH_3X3 = {
		8'd129, 8'd0, 8'd255, 8'd128, 8'd128, 8'd127, 8'd128, 8'd255, 8'd0
	};

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;

	lbp_stream_if #(.T(lbp_in_t))  pix ();
	lbp_stream_if #(.T(lbp_out_t)) res ();

	lbp_3x3_image_filter dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.pix       (pix),
		.res       (res)
	);

	// predictor state
	logic [CFG_W-1:0] width_reg;
	logic [CFG_W-1:0] height_reg;
	logic [PIX_W-1:0] line_above [MAX_W];
	logic [PIX_W-1:0] line_mid [MAX_W];
	logic [PIX_W-1:0] win [9];
	int unsigned      in_pos;
	lbp_out_t         lbp_pixels_due [$];

	int unsigned errors = 0;
	int unsigned items_taken = 0;
	bit          steady = 1'b0;
	bit          hold_req = 1'b0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int unsigned sat_size(logic [CFG_W-1:0] v, int unsigned hi);
		if (v < 3)
			return 3;
		if (v > hi)
			return hi;
		return 32'(v);
	endfunction

	// next output pixel of the filter for one beat; returns 0 when the beat is dropped
	function automatic bit predict_lbp_beat(lbp_in_t beat);
		int unsigned      w, h, total, q, ci, p, ro, co;
		logic [PIX_W-1:0] px, up, mid, ctr;
		lbp_out_t         r;
		w = sat_size(width_reg, MAX_W);
		h = sat_size(height_reg, MAX_H);
		total = w * h;
		px = beat.pixel;
		if (in_pos >= total + w + 1)
			in_pos = 0;
		// drain ahead of the tail is dropped, in the tail every beat drains
		if (in_pos < total) begin
			if (beat.func == FUNC_DRAIN)
				return 1'b0;
		end else begin
			px = '0;
		end
		// line stores shift up one row, window shifts left one column
		q = in_pos;
		ci = q % w;
		up = line_above[ci];
		mid = line_mid[ci];
		line_above[ci] = mid;
		line_mid[ci] = px;
		win[0] = win[1]; win[1] = win[2]; win[2] = up;
		win[3] = win[4]; win[4] = win[5]; win[5] = mid;
		win[6] = win[7]; win[7] = win[8]; win[8] = px;
		in_pos = q + 1;
		if (q < w + 1)
			return 1'b1;
		// output lags one row plus one pixel
		p = q - w - 1;
		ro = p / w;
		co = p % w;
		ctr = win[4];
		if (ro >= 1 && ro + 2 <= h && co >= 1 && co + 2 <= w)
			r.value = {win[8] >= ctr, win[7] >= ctr, win[6] >= ctr, win[5] >= ctr,
				win[3] >= ctr, win[2] >= ctr, win[1] >= ctr, win[0] >= ctr};
		else
			r.value = ctr;
		r.row = POS_W'(ro);
		r.col = POS_W'(co);
		r.last = (p + 1 == total);
		if (r.last)
			in_pos = 0;
		lbp_pixels_due.push_back(r);
		return 1'b1;
	endfunction

	// one input beat, with random idle cycles ahead of it
	task automatic send_beat(logic func, logic [PIX_W-1:0] value);
		lbp_in_t     beat;
		int unsigned gap;
		beat.func = func;
		beat.pixel = value;
		gap = 0;
		while (!steady && $urandom_range(99) < IDLE_PCT)
			gap++;
		if (gap != 0) begin
			pix.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pix.valid <= 1'b1;
		pix.data <= beat;
		do @(negedge clk); while (!pix.ready);
		if (predict_lbp_beat(beat))
			items_taken++;
		@(posedge clk);
	endtask

	// stop sending and let every pending result come out
	task automatic wait_quiet();
		pix.valid <= 1'b0;
		while (lbp_pixels_due.size() != 0)
			@(negedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= CFG_W'(val);
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_FRAME_WIDTH: width_reg = CFG_W'(val);
			REG_FRAME_HEIGHT: height_reg = CFG_W'(val);
			default: ;
		endcase
		// any write restarts the frame
		in_pos = 0;
		@(posedge clk);
	endtask

	task automatic set_frame(int unsigned w, int unsigned h);
		wait_quiet();
		write_reg(REG_FRAME_WIDTH, w);
		write_reg(REG_FRAME_HEIGHT, h);
	endtask

	// one frame and its tail; a cut below w*h stops early, noise adds stray drains
	task automatic send_frame(int unsigned w, int unsigned h, int unsigned cut,
			int unsigned noise_pct);
		int unsigned total, base;
		bit          ties;
		total = w * h;
		ties = 1'($urandom_range(1));
		base = $urandom_range(253);
		for (int unsigned i = 0; i < total && i < cut; i++) begin
			if ($urandom_range(99) < noise_pct)
				send_beat(FUNC_DRAIN, 8'($urandom));
			send_beat(FUNC_PIXEL, ties ? 8'(base + $urandom_range(2)) : 8'($urandom));
		end
		if (cut >= total)
			for (int unsigned i = 0; i <= w; i++)
				send_beat($urandom_range(1) ? FUNC_DRAIN : FUNC_PIXEL, 8'($urandom));
	endtask

	// power-up size 640x480: four results of the first row, then cut off
	task automatic test_reset_size();
		send_frame(640, 480, 645, 0);
	endtask

	task automatic test_directed_frames();
		set_frame(3, 3);
		// drain ahead of a complete frame
		send_beat(FUNC_DRAIN, 8'hFF);
		for (int i = 0; i < 9; i++)
			send_beat(FUNC_PIXEL, PATCH_3X3[i]);
		// tail: drains and pixels that act as drains
		send_beat(FUNC_DRAIN, 8'h00);
		send_beat(FUNC_PIXEL, 8'hFF);
		send_beat(FUNC_DRAIN, 8'h00);
		send_beat(FUNC_PIXEL, 8'h5A);
		// flat white frame right after the last beat, all neighbors tie
		for (int i = 0; i < 9; i++)
			send_beat(FUNC_PIXEL, 8'hFF);
		for (int i = 0; i < 4; i++)
			send_beat(FUNC_PIXEL, 8'h00);
	endtask

	// sizes below 3 and above the maximum saturate
	task automatic test_size_clamp();
		set_frame(0, 1);
		send_frame(3, 3, 9, 0);
		set_frame(1, 2);
		send_frame(3, 3, 9, 0);
		// oversize width: first results only once a full maximum row plus one pixel is in
		set_frame(2047, 2);
		send_frame(MAX_W, 3, MAX_W + 3, 0);
	endtask

	// register writes in the middle of a frame start a new one
	task automatic test_restart();
		set_frame(6, 5);
		send_frame(6, 5, 10, 0);
		set_frame(4, 4);
		send_frame(4, 4, 10, 0);
		wait_quiet();
		write_reg(REG_FRAME_HEIGHT, 3);
		send_frame(4, 3, 12, 0);
	endtask

	task automatic test_random_frames();
		int unsigned w, h, cut, frames, start;
		bit          hold_done;
		w = 3;
		h = 3;
		frames = 0;
		hold_done = 1'b0;
		start = items_taken;
		while (items_taken - start < RAND_ITEMS) begin
			// new sizes for most frames, the rest follow back to back
			if (frames == 0 || $urandom_range(3) != 0) begin
				w = ($urandom_range(9) == 0) ? $urandom_range(11, 40) : $urandom_range(3, 10);
				h = $urandom_range(3, 8);
				set_frame(w, h);
			end
			// a stretch with no idling on either side, with one long receiver hold
			steady = (items_taken - start >= RAND_ITEMS / 3) &&
				(!hold_done || items_taken - start < RAND_ITEMS / 2);
			if (steady && !hold_done) begin
				hold_req = 1'b1;
				hold_done = 1'b1;
			end
			cut = ($urandom_range(9) == 0) ? $urandom_range(1, w * h - 1) : w * h;
			send_frame(w, h, cut, 5);
			// broken frame: restart it by a register write
			if (cut < w * h)
				set_frame(w, h);
			frames++;
		end
		steady = 1'b0;
	endtask

	// receiver: random stalls, or one long hold counted here
	initial begin
		int unsigned hold_left;
		hold_left = 0;
		res.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left != 0) begin
				hold_left--;
				res.ready <= 1'b0;
			end else if (hold_req) begin
				hold_req = 1'b0;
				hold_left = HOLD_CYCLES - 1;
				res.ready <= 1'b0;
			end else begin
				res.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
			end
		end
	end

	function automatic void check_field(string field, logic [31:0] want, logic [31:0] got,
			lbp_out_t at);
		if (want !== got) begin
			errors++;
			$display("%0t: %s mismatch at row %0d col %0d: expected %0d, got %0d",
				$time, field, at.row, at.col, want, got);
		end
	endfunction

	// result beats against the oldest pending output pixel
	initial begin
		lbp_out_t got, want;
		forever begin
			@(negedge clk);
			if (arst_n && res.valid && res.ready) begin
				got = res.data;
				@(posedge clk);
				if (lbp_pixels_due.size() == 0) begin
					errors++;
					$display("%0t: stray result: expected none, got %0d at %0d,%0d last %0d",
						$time, got.value, got.row, got.col, got.last);
				end else begin
					want = lbp_pixels_due.pop_front();
					check_field("value", 32'(want.value), 32'(got.value), want);
					check_field("row", 32'(want.row), 32'(got.row), want);
					check_field("col", 32'(want.col), 32'(got.col), want);
					check_field("last", 32'(want.last), 32'(got.last), want);
				end
			end
		end
	end

	// watchdog on cycles with no beat on either side
	initial begin
		int unsigned quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(negedge clk);
			if ((pix.valid && pix.ready) || (res.valid && res.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= REG_FRAME_WIDTH;
		cfg_data <= '0;
		pix.valid <= 1'b0;
		pix.data <= '0;
		// predictor after reset
		width_reg = FRAME_WIDTH_RST;
		height_reg = FRAME_HEIGHT_RST;
		in_pos = 0;
		for (int i = 0; i < MAX_W; i++) begin
			line_above[i] = '0;
			line_mid[i] = '0;
		end
		for (int i = 0; i < 9; i++)
			win[i] = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_size();
		test_directed_frames();
		test_size_clamp();
		test_restart();
		test_random_frames();
		wait_quiet();
		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

>>> files.f
+incdir+rtl
rtl/lbp_pkg.sv
rtl/lbp_stream_if.sv
rtl/lbp_ram.sv
rtl/lbp_pos.sv
rtl/lbp_win.sv
rtl/lbp_3x3_image_filter.sv
rtl/lbp_checker.sv
tb/lbp_3x3_image_filter_tb.sv
